// ===== rtl/core/wlsf_pkg.sv =====
`default_nettype none
package wlsf_pkg;
   localparam int FracBitsDefault = 16;
   localparam int AccWidthDefault = 64;
   localparam int DataWidth = 32;
   localparam int DiscWidth = 17;
   localparam int DiscShift = 16;
   localparam logic [DiscWidth-1:0] DiscReset = 17'h10000;

   typedef struct packed {
      logic            sample_valid;
      logic [31:0]     ctrl_sample;
      logic [31:0]     measure_sample;
      logic [31:0]     query_ctrl;
      logic [31:0]     target_measure;
   } req_type;

   typedef struct packed {
      logic [31:0] slope;
      logic [31:0] intercept;
      logic [31:0] predicted_measure;
      logic [31:0] ctrl_for_target;
      logic        singular;
      logic        no_solution;
   } rsp_type;

   // micro-operations issued by the controller
   localparam logic [4:0] OpScaleSxx = 5'd0;
   localparam logic [4:0] OpScaleSx  = 5'd1;
   localparam logic [4:0] OpScaleS1  = 5'd2;
   localparam logic [4:0] OpScaleSxm = 5'd3;
   localparam logic [4:0] OpScaleSm  = 5'd4;
   localparam logic [4:0] OpAddSxx   = 5'd5;
   localparam logic [4:0] OpAddRest  = 5'd6;
   localparam logic [4:0] OpDetA     = 5'd7;
   localparam logic [4:0] OpDetB     = 5'd8;
   localparam logic [4:0] OpDivI00   = 5'd9;
   localparam logic [4:0] OpDivI01   = 5'd10;
   localparam logic [4:0] OpDivI11   = 5'd11;
   localparam logic [4:0] OpSlopeA   = 5'd12;
   localparam logic [4:0] OpSlopeB   = 5'd13;
   localparam logic [4:0] OpIcptA    = 5'd14;
   localparam logic [4:0] OpIcptB    = 5'd15;
   localparam logic [4:0] OpPred     = 5'd16;
   localparam logic [4:0] OpSolve    = 5'd17;
   localparam logic [4:0] OpIdle     = 5'd18;

   typedef struct packed {
      logic       load;    // capture request
      logic       start;   // start micro-op
      logic [4:0] op;
      logic       emit;    // load output register
   } cmd_type;

   typedef struct packed {
      logic busy;          // micro-op in progress
      logic sample;        // request carries a sample
      logic det_zero;
   } sts_type;
endpackage
`default_nettype wire

// ===== rtl/core/wlsf_if.sv =====
`default_nettype none
interface wlsf_req_if;
   import wlsf_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface wlsf_rsp_if;
   import wlsf_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/wlsf_div.sv =====
`default_nettype none
// radix-2 restoring divider, 128 by 64, one quotient bit per cycle
module wlsf_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num_hi,
   input  wire logic [63:0] num_lo,
   input  wire logic [63:0] den,
   output logic             busy,
   output logic [63:0]      quot,
   output logic             ovf
);
   logic [127:0] n_ff, n_in;
   logic [63:0]  r_ff, r_in, q_ff, q_in, d_ff, d_in;
   logic         o_ff, o_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic [64:0]  trial;
   logic         take;

   always_comb begin
      n_in = n_ff; r_in = r_ff; q_in = q_ff; d_in = d_ff; o_in = o_ff;
      cnt_in = cnt_ff;
      trial = {r_ff, n_ff[127]};
      take = trial >= {1'b0, d_ff};
      if (start) begin
         n_in = {num_hi, num_lo}; r_in = '0; q_in = '0; d_in = den; o_in = 1'b0;
         cnt_in = 8'd128;
      end else if (cnt_ff != 8'd0) begin
         n_in = {n_ff[126:0], 1'b0};
         r_in = take ? 64'(trial - {1'b0, d_ff}) : trial[63:0];
         if (take && cnt_ff > 8'd64) o_in = 1'b1;
         q_in = {q_ff[62:0], (cnt_ff <= 8'd64) ? take : 1'b0};
         cnt_in = cnt_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; r_ff <= r_in; q_ff <= q_in; d_ff <= d_in; o_ff <= o_in;
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   assign busy = cnt_ff != 8'd0;
   assign quot = q_ff;
   assign ovf = o_ff;
endmodule
`default_nettype wire

// ===== rtl/core/wlsf_mul.sv =====
`default_nettype none
// 64x64 magnitude multiply from 32x32 partial products, one per cycle
module wlsf_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic             busy,
   output logic [127:0]     prod
);
   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [127:0] p_ff, p_in;
   logic [2:0]   st_ff, st_in;
   logic [63:0]  pp_ff, pp_in;
   logic [31:0]  x, y;
   logic [6:0]   sh;

   always_comb begin
      a_in = a_ff; b_in = b_ff; p_in = p_ff; st_in = st_ff;
      x = st_ff[1] ? a_ff[63:32] : a_ff[31:0];
      y = st_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp_in = 64'(x) * 64'(y);
      sh = 7'((st_ff - 3'd1) == 3'd3 ? 64 : ((st_ff - 3'd1) == 3'd0 ? 0 : 32));
      if (start) begin
         a_in = a; b_in = b; p_in = '0; st_in = 3'd0;
      end else if (st_ff != 3'd5) begin
         if (st_ff != 3'd0) p_in = p_ff + (128'(pp_ff) << sh);
         st_in = st_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; p_ff <= p_in; pp_ff <= pp_in;
      if (reset) st_ff <= 3'd5;
      else st_ff <= st_in;
   end

   assign busy = start || st_ff != 3'd5;
   assign prod = p_ff;
endmodule
`default_nettype wire

// ===== rtl/core/wlsf_datapath.sv =====
`default_nettype none
module wlsf_datapath #(
   parameter int FRAC_BITS = wlsf_pkg::FracBitsDefault,
   parameter int ACC_WIDTH = wlsf_pkg::AccWidthDefault
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire wlsf_pkg::cmd_type            cmd,
   output wlsf_pkg::sts_type                 sts,
   input  wire wlsf_pkg::req_type            req,
   input  wire logic [wlsf_pkg::DiscWidth-1:0] discount,
   output wlsf_pkg::rsp_type                 rsp
);
   import wlsf_pkg::*;

   localparam logic signed [63:0] OneFx = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] AccMax = 64'h7fff_ffff_ffff_ffff >>> (64 - ACC_WIDTH);
   localparam logic signed [63:0] AccMin = -AccMax - 64'sd1;
   localparam logic signed [63:0] S64Max = 64'h7fff_ffff_ffff_ffff;
   localparam logic signed [63:0] S64Min = 64'h8000_0000_0000_0000;

   function automatic logic [63:0] mag(input logic signed [63:0] v);
      mag = v[63] ? 64'(-v) : v;
   endfunction
   function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg);
      logic [63:0] c;
      c = m[63] ? 64'h7fff_ffff_ffff_ffff : m;
      from_mag = neg ? 64'(-c) : c;
   endfunction
   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(S64Max)) sat_add = S64Max;
      else if (s < 65'(S64Min)) sat_add = S64Min;
      else sat_add = s[63:0];
   endfunction
   function automatic logic signed [63:0] accs(input logic signed [63:0] v);
      accs = v < AccMin ? AccMin : (v > AccMax ? AccMax : v);
   endfunction
   function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
      sat32 = v < -64'sd2147483648 ? -64'sd2147483648 :
              (v > 64'sd2147483647 ? 64'sd2147483647 : v);
   endfunction
   function automatic logic signed [63:0] neg_sat(input logic signed [63:0] v);
      neg_sat = v == S64Min ? S64Max : 64'(-v);
   endfunction

   logic signed [63:0] sxx_ff, sx_ff, s1_ff, sxm_ff, sm_ff;
   logic signed [63:0] sxx_in, sx_in, s1_in, sxm_in, sm_in;
   logic signed [63:0] i00_ff, i01_ff, i11_ff, i00_in, i01_in, i11_in;
   logic               sing_ff, sing_in;
   logic signed [63:0] t_ff, t_in, det_ff, det_in;
   logic signed [63:0] slope_ff, slope_in, icpt_ff, icpt_in, pred_ff, pred_in;
   logic signed [63:0] sol_ff, sol_in;
   logic               nosol_ff, nosol_in;
   req_type            req_ff;
   rsp_type            rsp_ff;
   logic [4:0]         op_ff;
   logic               neg_ff;
   logic               wait_ff;
   logic               sample_ff;

   // operand select for the shared multiplier and divider
   logic signed [63:0] ma, mb, dn, dd, csx, msx, qsx, tsx;
   logic [6:0]         msh;
   logic               mbusy, dbusy, dovf, use_div;
   logic [127:0]       mprod;
   logic [63:0]        dq, nmag;
   logic [63:0]        mq;
   logic signed [63:0] mres, dres;
   logic [63:0]        dnum_hi, dnum_lo;

   assign csx = 64'(signed'(req_ff.ctrl_sample));
   assign msx = 64'(signed'(req_ff.measure_sample));
   assign qsx = 64'(signed'(req_ff.query_ctrl));
   assign tsx = 64'(signed'(req_ff.target_measure));

   always_comb begin
      ma = '0; mb = '0; msh = 7'(FRAC_BITS); dn = '0; dd = 64'sd1; use_div = 1'b0;
      unique case (cmd.op)
         OpScaleSxx: begin ma = sxx_ff; mb = 64'(discount); msh = 7'(DiscShift); end
         OpScaleSx:  begin ma = sx_ff;  mb = 64'(discount); msh = 7'(DiscShift); end
         OpScaleS1:  begin ma = s1_ff;  mb = 64'(discount); msh = 7'(DiscShift); end
         OpScaleSxm: begin ma = sxm_ff; mb = 64'(discount); msh = 7'(DiscShift); end
         OpScaleSm:  begin ma = sm_ff;  mb = 64'(discount); msh = 7'(DiscShift); end
         OpAddSxx:   begin ma = csx; mb = csx; end
         OpAddRest:  begin ma = csx; mb = msx; end
         OpDetA:     begin ma = sxx_ff; mb = s1_ff; end
         OpDetB:     begin ma = sx_ff; mb = sx_ff; end
         OpDivI00:   begin dn = s1_ff; dd = det_ff; use_div = 1'b1; end
         OpDivI01:   begin dn = sx_ff; dd = det_ff; use_div = 1'b1; end
         OpDivI11:   begin dn = sxx_ff; dd = det_ff; use_div = 1'b1; end
         OpSlopeA:   begin ma = i00_ff; mb = sxm_ff; end
         OpSlopeB:   begin ma = i01_ff; mb = sm_ff; end
         OpIcptA:    begin ma = i01_ff; mb = sxm_ff; end
         OpIcptB:    begin ma = i11_ff; mb = sm_ff; end
         OpPred:     begin ma = slope_ff; mb = qsx; end
         OpSolve:    begin dn = tsx - icpt_ff; dd = slope_ff; use_div = 1'b1; end
         default:    begin ma = '0; end
      endcase
      nmag = mag(dn);
      dnum_hi = 64'(128'(nmag) >> (64 - FRAC_BITS));
      dnum_lo = nmag << FRAC_BITS;
   end

   logic [6:0] sh_ff;
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         neg_ff <= use_div ? (dn[63] != dd[63]) : (ma[63] != mb[63]);
         sh_ff <= msh;
      end
   end

   wlsf_mul u_mul (
      .clock(clock), .reset(reset), .start(cmd.start && !use_div),
      .a(mag(ma)), .b(mag(mb)), .busy(mbusy), .prod(mprod)
   );
   wlsf_div u_div (
      .clock(clock), .reset(reset), .start(cmd.start && use_div),
      .num_hi(dnum_hi), .num_lo(dnum_lo), .den(mag(dd)),
      .busy(dbusy), .quot(dq), .ovf(dovf)
   );

   always_comb begin
      mq = (mprod >> sh_ff) > 128'(64'hffff_ffff_ffff_ffff) ? 64'hffff_ffff_ffff_ffff
                                                            : 64'(mprod >> sh_ff);
      mres = from_mag(mq, neg_ff);
      dres = from_mag(dovf ? 64'hffff_ffff_ffff_ffff : dq, neg_ff);
   end

   // apply the finished micro-op once the unit goes idle
   always_comb begin
      sxx_in = sxx_ff; sx_in = sx_ff; s1_in = s1_ff; sxm_in = sxm_ff; sm_in = sm_ff;
      i00_in = i00_ff; i01_in = i01_ff; i11_in = i11_ff; sing_in = sing_ff;
      t_in = t_ff; det_in = det_ff; slope_in = slope_ff; icpt_in = icpt_ff;
      pred_in = pred_ff; sol_in = sol_ff; nosol_in = nosol_ff;
      if (wait_ff && !mbusy && !dbusy) begin
         unique case (op_ff)
            OpScaleSxx: sxx_in = accs(mres);
            OpScaleSx:  sx_in = accs(mres);
            OpScaleS1:  s1_in = accs(mres);
            OpScaleSxm: sxm_in = accs(mres);
            OpScaleSm:  sm_in = accs(mres);
            OpAddSxx:   sxx_in = accs(sat_add(sxx_ff, mres));
            OpAddRest: begin
               sxm_in = accs(sat_add(sxm_ff, mres));
               sx_in = accs(sat_add(sx_ff, csx));
               s1_in = accs(sat_add(s1_ff, OneFx));
               sm_in = accs(sat_add(sm_ff, msx));
            end
            OpDetA: t_in = mres;
            OpDetB: begin
               det_in = sat_add(t_ff, neg_sat(mres));
               if (sat_add(t_ff, neg_sat(mres)) == 64'sd0) begin
                  i00_in = OneFx; i01_in = '0; i11_in = OneFx; sing_in = 1'b1;
               end else begin
                  sing_in = 1'b0;
               end
            end
            OpDivI00: i00_in = accs(dres);
            OpDivI01: i01_in = accs(neg_sat(dres));
            OpDivI11: i11_in = accs(dres);
            OpSlopeA: t_in = mres;
            OpSlopeB: slope_in = sat32(sat_add(t_ff, mres));
            OpIcptA:  t_in = mres;
            OpIcptB:  icpt_in = sat32(sat_add(t_ff, mres));
            OpPred: begin
               pred_in = sat32(sat_add(mres, icpt_ff));
               nosol_in = slope_ff == 64'sd0;
               sol_in = '0;
            end
            // a zero slope has no solution, the result stays zero
            OpSolve: sol_in = nosol_ff ? 64'sd0 : sat32(dres);
            default: t_in = t_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sxx_ff <= '0; sx_ff <= '0; s1_ff <= '0; sxm_ff <= OneFx; sm_ff <= OneFx;
         i00_ff <= OneFx; i01_ff <= '0; i11_ff <= OneFx; sing_ff <= 1'b1;
         wait_ff <= 1'b0;
      end else begin
         sxx_ff <= sxx_in; sx_ff <= sx_in; s1_ff <= s1_in; sxm_ff <= sxm_in;
         sm_ff <= sm_in; i00_ff <= i00_in; i01_ff <= i01_in; i11_ff <= i11_in;
         sing_ff <= sing_in;
         if (cmd.start) wait_ff <= 1'b1;
         else if (!mbusy && !dbusy) wait_ff <= 1'b0;
      end
      t_ff <= t_in; det_ff <= det_in; slope_ff <= slope_in; icpt_ff <= icpt_in;
      pred_ff <= pred_in; sol_ff <= sol_in; nosol_ff <= nosol_in;
      if (cmd.start) op_ff <= cmd.op;
      if (cmd.load) begin
         req_ff <= req;
         sample_ff <= req.sample_valid;
      end
      if (cmd.emit) begin
         rsp_ff.slope <= slope_ff[31:0];
         rsp_ff.intercept <= icpt_ff[31:0];
         rsp_ff.predicted_measure <= pred_ff[31:0];
         rsp_ff.ctrl_for_target <= sol_ff[31:0];
         rsp_ff.singular <= sing_ff;
         rsp_ff.no_solution <= nosol_ff;
      end
   end

   assign sts = '{busy: cmd.start || wait_ff, sample: sample_ff, det_zero: sing_ff};
   assign rsp = rsp_ff;
endmodule
`default_nettype wire

// ===== rtl/core/wlsf_ctrl.sv =====
`default_nettype none
module wlsf_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_fire,
   input  wire logic              rsp_ready,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire wlsf_pkg::sts_type sts,
   output wlsf_pkg::cmd_type      cmd
);
   import wlsf_pkg::*;

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StIssue = 2'd1;
   localparam logic [1:0] StWait = 2'd2;

   logic [1:0] st_ff, st_in;
   logic [4:0] op_ff, op_in;
   logic       full_ff, full_in;
   logic [4:0] nxt;

   always_comb begin
      unique case (op_ff)
         OpDetB:   nxt = sts.det_zero ? OpSlopeA : OpDivI00;
         OpSolve:  nxt = OpIdle;
         default:  nxt = op_ff + 5'd1;
      endcase
   end

   always_comb begin
      st_in = st_ff; op_in = op_ff; full_in = full_ff;
      cmd = '0; cmd.op = op_ff;
      if (full_ff && rsp_ready) full_in = 1'b0;
      unique case (st_ff)
         StIdle: begin
            if (req_fire) begin
               cmd.load = 1'b1; st_in = StIssue; op_in = OpIdle;
            end
         end
         StIssue: begin
            if (op_ff == OpIdle) op_in = sts.sample ? OpScaleSxx : OpSlopeA;
            else begin cmd.start = 1'b1; st_in = StWait; end
         end
         StWait: begin
            if (!sts.busy) begin
               if (op_ff == OpPred && sts.busy == 1'b0) begin
                  op_in = OpSolve; st_in = StIssue;
               end else if (nxt == OpIdle) begin
                  if (!full_in) begin
                     cmd.emit = 1'b1; full_in = 1'b1; st_in = StIdle;
                  end
               end else begin
                  op_in = nxt; st_in = StIssue;
               end
            end
         end
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= StIdle; op_ff <= OpIdle; full_ff <= 1'b0;
      end else begin
         st_ff <= st_in; op_ff <= op_in; full_ff <= full_in;
      end
   end

   assign req_ready = st_ff == StIdle;
   assign rsp_valid = full_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !full_ff || rsp_ready) else $error("result overwritten");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.start)) else $error("load and start together");
   a_start_after_issue: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> st_ff == StWait) else $error("start lost");
endmodule
`default_nettype wire

// ===== rtl/core/weighted_least_squares_line_fit_unit.sv =====
`default_nettype none
// online weighted least-squares line fit, measure = slope*ctrl + intercept, Q16.16.
// one request at a time. a request with a sample runs nine 64x64 products for the
// five discount scalings, the adds and the determinant, three 128/64 divisions for
// the inverse, five more products for slope, intercept and prediction, then the ctrl
// solve division; a sample that leaves the determinant at zero skips the inverse
// divisions; a query-only request skips the scalings, adds, determinant and inverse.
// the multiplier is built of 32x32 partial products, the divider gives one quotient
// bit per cycle. the result sits in an output register so the next request is
// taken while it waits. the user must write discount through csr_ only while idle;
// the block does not enforce it.
module weighted_least_squares_line_fit_unit #(
   parameter int FRAC_BITS = wlsf_pkg::FracBitsDefault,
   parameter int ACC_WIDTH = wlsf_pkg::AccWidthDefault
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   wlsf_req_if.sink                            req,
   wlsf_rsp_if.source                          rsp,
   input  wire logic                           csr_write_enable,
   input  wire logic [wlsf_pkg::DiscWidth-1:0] csr_write_data
);
   import wlsf_pkg::*;

   // discount register
   logic [DiscWidth-1:0] disc_ff;
   cmd_type cmd;
   sts_type sts;
   logic    req_fire;

   always_ff @(posedge clock) begin
      if (reset) disc_ff <= DiscReset;
      else if (csr_write_enable) disc_ff <= csr_write_data;
   end

   assign req_fire = req.valid && req.ready;

   // sequencer
   wlsf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .rsp_ready(rsp.ready),
      .req_ready(req.ready), .rsp_valid(rsp.valid), .sts(sts), .cmd(cmd)
   );

   // sums, inverse and shared arithmetic
   wlsf_datapath #(.FRAC_BITS(FRAC_BITS), .ACC_WIDTH(ACC_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .req(req.payload),
      .discount(disc_ff), .rsp(rsp.payload)
   );
endmodule
`default_nettype wire

// ===== sim/wlsf_line_fit_checker.sv =====
`timescale 1ns / 1ps
module wlsf_line_fit_checker (
   input  logic                           clock,
   input  logic                           reset,
   wlsf_req_if                            req,
   wlsf_rsp_if                            rsp,
   input  logic                           csr_write_enable,
   input  logic [wlsf_pkg::DiscWidth-1:0] csr_write_data,
   output int                             mismatch_count,
   output int                             outstanding
);
   import wlsf_pkg::*;

   localparam int Frac = FracBitsDefault;
   localparam longint OneFx = longint'(1) <<< Frac;
   localparam logic [63:0] MaxMag = 64'h7fff_ffff_ffff_ffff;

   // fit state, mirrors the block
   logic [DiscWidth-1:0] discount;
   longint sxx, sx, s1, sxm, sm;
   longint inv00, inv01, inv11;
   bit     singular_now;
   rsp_type fit_results[$];

   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint signed_from(logic [63:0] m, bit neg);
      logic [63:0] c;
      c = (m > MaxMag) ? MaxMag : m;
      return neg ? -longint'(c) : longint'(c);
   endfunction

   function automatic longint add_sat(longint a, longint b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return longint'(s[63:0]);
   endfunction

   // exact product, magnitude shifted right, saturated
   function automatic longint mul_fx(longint a, longint b, int sh);
      logic [127:0] p;
      p = {64'b0, magnitude(a)} * {64'b0, magnitude(b)};
      p = p >> sh;
      if (p[127:64] != 0) p[63:0] = '1;
      return signed_from(p[63:0], (a < 0) != (b < 0));
   endfunction

   function automatic longint div_fx(longint n, longint d, int sh);
      logic [127:0] num, q;
      if (d == 0) return 0;
      num = {64'b0, magnitude(n)} << sh;
      q = num / {64'b0, magnitude(d)};
      if (q[127:64] != 0) q[63:0] = '1;
      return signed_from(q[63:0], (n < 0) != (d < 0));
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   task automatic clear_fit();
      discount = DiscReset;
      sxx = 0; sx = 0; s1 = 0; sxm = OneFx; sm = OneFx;
      inv00 = OneFx; inv01 = 0; inv11 = OneFx;
      singular_now = 1;
   endtask

   task automatic fold_sample(longint c, longint m);
      longint d, det;
      d = longint'(discount);
      sxx = mul_fx(sxx, d, DiscShift);
      sx = mul_fx(sx, d, DiscShift);
      s1 = mul_fx(s1, d, DiscShift);
      sxm = mul_fx(sxm, d, DiscShift);
      sm = mul_fx(sm, d, DiscShift);
      sxx = add_sat(sxx, mul_fx(c, c, Frac));
      sx = add_sat(sx, c);
      s1 = add_sat(s1, OneFx);
      sxm = add_sat(sxm, mul_fx(c, m, Frac));
      sm = add_sat(sm, m);
      det = add_sat(mul_fx(sxx, s1, Frac), -mul_fx(sx, sx, Frac));
      if (det == 0) begin
         inv00 = OneFx; inv01 = 0; inv11 = OneFx;
         singular_now = 1;
      end else begin
         inv00 = div_fx(s1, det, Frac);
         inv01 = -div_fx(sx, det, Frac);
         inv11 = div_fx(sxx, det, Frac);
         singular_now = 0;
      end
   endtask

   task automatic predict_fit(req_type r, output rsp_type e);
      longint c, m, q, t, slope, icpt, pred, sol;
      c = $signed(r.ctrl_sample);
      m = $signed(r.measure_sample);
      q = $signed(r.query_ctrl);
      t = $signed(r.target_measure);
      if (r.sample_valid) fold_sample(c, m);
      slope = clamp32(add_sat(mul_fx(inv00, sxm, Frac), mul_fx(inv01, sm, Frac)));
      icpt = clamp32(add_sat(mul_fx(inv01, sxm, Frac), mul_fx(inv11, sm, Frac)));
      pred = clamp32(add_sat(mul_fx(slope, q, Frac), icpt));
      sol = (slope == 0) ? 0 : clamp32(div_fx(t - icpt, slope, Frac));
      e.slope = slope[31:0];
      e.intercept = icpt[31:0];
      e.predicted_measure = pred[31:0];
      e.ctrl_for_target = sol[31:0];
      e.singular = singular_now;
      e.no_solution = (slope == 0);
   endtask

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         $display("%0t: %s mismatch, got %h expected %h", $realtime, field, got, want);
         mismatch_count++;
      end
   endtask

   initial begin
      mismatch_count = 0;
      clear_fit();
   end

   assign outstanding = fit_results.size();

   always @(posedge clock) begin
      rsp_type e, g;
      if (reset) begin
         clear_fit();
         fit_results.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            g = rsp.payload;
            if (fit_results.size() == 0) begin
               $display("%0t: result with no request pending", $realtime);
               mismatch_count++;
            end else begin
               e = fit_results.pop_front();
               report("slope", g.slope, e.slope);
               report("intercept", g.intercept, e.intercept);
               report("predicted_measure", g.predicted_measure, e.predicted_measure);
               report("ctrl_for_target", g.ctrl_for_target, e.ctrl_for_target);
               report("singular", 32'(g.singular), 32'(e.singular));
               report("no_solution", 32'(g.no_solution), 32'(e.no_solution));
            end
         end
         if (csr_write_enable) discount = csr_write_data;
         if (req.valid && req.ready) begin
            predict_fit(req.payload, e);
            fit_results.push_back(e);
         end
      end
   end
endmodule

// ===== sim/tb_weighted_least_squares_line_fit_unit.sv =====
`timescale 1ns / 1ps
module tb_weighted_least_squares_line_fit_unit;
   import wlsf_pkg::*;

   // cycles with no handshake at all before the run is declared hung
   localparam int StallLimit = 20000;
   localparam int RequestsPerPhase = 145;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [DiscWidth-1:0] csr_write_data;
   int                   mismatch_count;
   int                   outstanding;
   int                   quiet_cycles;
   bit                   calm;     // no idling on either side
   int                   ready_hold;

   wlsf_req_if req_if();
   wlsf_rsp_if rsp_if();

   weighted_least_squares_line_fit_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   wlsf_line_fit_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   always #5 clock = ~clock;

   // random response side back-pressure, none while calm
   always @(negedge clock) begin
      if (calm) begin
         rsp_if.ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         ready_hold <= $urandom_range(0, 4);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // hang detection: count cycles in which neither channel moves
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called and returns at a falling edge; between requests valid stays high while calm
   task automatic send_request(req_type r);
      bit taken;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= r;
      do begin
         @(posedge clock);
         taken = req_if.valid && req_if.ready;
         @(negedge clock);
      end while (!taken);
   endtask

   // discount may only change with nothing in flight
   task automatic write_discount(logic [DiscWidth-1:0] value);
      req_if.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic req_type make_request(bit smp, logic [31:0] c, logic [31:0] m,
                                            logic [31:0] q, logic [31:0] t);
      req_type r;
      r.sample_valid = smp;
      r.ctrl_sample = c;
      r.measure_sample = m;
      r.query_ctrl = q;
      r.target_measure = t;
      return r;
   endfunction

   // mix of full-range, small, moderate and corner values
   function automatic logic [31:0] any_value();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
         2: return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0;
               default: return 32'h0001_0000;
            endcase
         end
      endcase
   endfunction

   initial begin
      logic [DiscWidth-1:0] discounts [7];
      int line_gain, line_offset, c;
      logic [31:0] m;
      discounts = '{17'h10000, 17'h0, 17'h1, 17'h0ffff, 17'h1ffff, 17'h0e666, 17'h0};
      discounts[6] = $urandom_range(0, 131071);

      clock = 1'b0;
      reset = 1'b1;
      calm = 1'b0;
      ready_hold = 0;
      quiet_cycles = 0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: fresh state is singular with identity inverse
      send_request(make_request(0, 0, 0, 0, 0));
      send_request(make_request(0, 32'hffff_ffff, 32'h1, 32'h7fff_ffff, 32'h8000_0000));
      // a single point leaves the determinant at zero
      send_request(make_request(1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0));
      send_request(make_request(1, 32'h0003_0000, 32'h0004_0000, 32'h8000_0000, 32'h7fff_ffff));
      send_request(make_request(1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0));
      send_request(make_request(1, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'h8000_0000));
      send_request(make_request(1, 32'h0, 32'h0, 32'hffff_ffff, 32'h7fff_ffff));
      send_request(make_request(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000));
      send_request(make_request(1, 32'hffff_ffff, 32'h0000_0001, 32'h0, 32'hffff_ffff));
      // zero discount forgets everything: one zero point gives zero slope
      write_discount(17'h0);
      send_request(make_request(1, 32'h0, 32'h0, 32'h0001_0000, 32'h0005_0000));
      send_request(make_request(0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000));
      send_request(make_request(1, 32'h0002_0000, 32'h7fff_ffff, 32'h0, 32'h0));
      // discount above one lets the sums run into saturation
      write_discount(17'h1ffff);
      repeat (4) send_request(make_request(1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                           32'h8000_0000));
      send_request(make_request(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0));

      // random phases, one per discount setting; the last runs without idling
      for (int p = 0; p < 7; p++) begin
         write_discount(discounts[p]);
         if (p == 6) calm = 1'b1;
         line_gain = $urandom_range(0, 6) - 3;
         line_offset = $urandom_range(0, 1 << 22) - (1 << 21);
         for (int i = 0; i < RequestsPerPhase; i++) begin
            if ($urandom_range(0, 3) == 0) begin
               // noise: unrelated fields, often query only
               send_request(make_request($urandom_range(0, 1), any_value(), any_value(),
                                         any_value(), any_value()));
            end else begin
               // points scattered around a straight line
               c = $urandom_range(0, 1 << 23) - (1 << 22);
               m = 32'(line_gain * c + line_offset + $urandom_range(0, 4095) - 2048);
               send_request(make_request($urandom_range(0, 4) != 0, c, m,
                                         any_value(), any_value()));
            end
         end
      end

      req_if.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (600) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
